>>> rtl/core/ihc_pkg.sv
// Shared types and helpers for the IPv4 header checksum unit.
// Holds the request/response word structs and the ones' complement lane arithmetic.
// No dependencies.
package ihc_pkg;

   localparam logic [15:0] LANE_ONES = 16'hFFFF;

   typedef struct packed {
      logic [63:0] in_data;
      logic [7:0]  in_keep;
      logic        in_last;
   } req_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [7:0]  out_keep;
      logic        out_last;
      logic        csum_valid;
      logic [15:0] csum;
   } rsp_type;

   // checksum outcome for the word in flight
   typedef struct packed {
      logic        fin;
      logic [15:0] csum;
   } ihc_sum_type;

   // position of a word within the header
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_BODY   = 2'd2
   } word_pos_type;

   // 16-bit ones' complement add with end-around carry
   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = {1'b0, s[15:0]} + {16'd0, s[16]};
      return t[15:0];
   endfunction

   // big-endian 16-bit lane of a word whose byte 0 sits in bits 7:0
   function automatic logic [15:0] lane_of(input logic [63:0] d, input logic [1:0] i);
      logic [15:0] raw;
      raw = d[{i, 4'd0} +: 16];
      return {raw[7:0], raw[15:8]};
   endfunction

endpackage

>>> rtl/core/ipv4_header_checksum_64b_unit.sv
// IPv4 header checksum unit, 64-bit stream: top level.
// Input word register, ihc_accum for the checksum, result register.
// Depends on ihc_pkg and ihc_accum.
//
// Usage:
//   req_* carries packet words (byte 0 in bits 7:0) with keep mask and last
//   flag. Every word comes back on rsp_* unchanged, in order, one response
//   per request. On the word that ends the header (IHL 32-bit words, or the
//   last word of a short or truncated packet) csum_valid is high and csum
//   holds the ones' complement header checksum; otherwise csum reads zero.
//   rsp_valid rises once an accepted word has waited in the input register and
//   the lane add and two-level fold have loaded the result register from it;
//   a stall holds it there. Throughput is one word per cycle while rsp_ready
//   is high; the cycle is set by the lane end-around-carry add and the fold tree.
//   When rsp_ready is low the result register holds and the input register
//   fills; req_ready falls only once both hold a word. Accumulator state
//   advances only as a word moves into the result register.
//   Reset (synchronous, active high) empties both registers and clears the
//   header state, so the next word is taken as the start of a packet.
module ipv4_header_checksum_64b_unit
   import ihc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type     s1_ff;
   logic        s1_valid_ff, s1_valid_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic        advance;
   logic        s1_go;
   ihc_sum_type sum;

   assign advance   = !out_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   ihc_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_go),
      .word   (s1_ff),
      .result (sum)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      if (advance) begin
         out_valid_in = s1_valid_ff;
      end
      out_in.out_data   = s1_ff.in_data;
      out_in.out_keep   = s1_ff.in_keep;
      out_in.out_last   = s1_ff.in_last;
      out_in.csum_valid = sum.fin;
      out_in.csum       = sum.csum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (s1_go) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("word dropped from input register");

   a_csum_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.csum_valid |-> out_ff.csum == 16'd0)
      else $error("checksum nonzero without csum_valid");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> out_valid_ff)
      else $error("word lost moving to result register");

endmodule

>>> rtl/core/ihc_accum.sv
// Header position tracking, four lane accumulators and the final fold.
// Depends on ihc_pkg for the word types and the lane arithmetic.
module ihc_accum
   import ihc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     word,
   output ihc_sum_type result
);

   word_pos_type pos_ff, pos_in;
   logic [3:0]   left_ff, left_in;
   logic [15:0]  lane_ff [4];
   logic [15:0]  lane_in [4];
   logic         done_ff, done_in;

   logic [3:0]   add_mask;
   logic [15:0]  lane_sum [4];
   logic [3:0]   left_calc;
   word_pos_type pos_calc;
   logic         fin;
   logic [15:0]  fold_a, fold_b, fold_s;

   // lane selection and header count for this word
   always_comb begin
      add_mask  = 4'b0000;
      left_calc = left_ff;
      pos_calc  = pos_ff;
      fin       = 1'b0;
      if (!done_ff) begin
         unique case (pos_ff)
            POS_FIRST: begin
               add_mask  = 4'b1111;
               left_calc = word.in_data[3:0] - 4'd2;
               pos_calc  = POS_SECOND;
            end
            POS_SECOND: begin
               // skip the checksum field in lane 1
               add_mask  = 4'b1101;
               left_calc = left_ff - 4'd2;
               pos_calc  = POS_BODY;
            end
            default: begin
               if (left_ff == 4'd1) begin
                  add_mask  = 4'b0011;
                  left_calc = 4'd0;
                  fin       = 1'b1;
               end else if (left_ff == 4'd2) begin
                  add_mask  = 4'b1111;
                  left_calc = 4'd0;
                  fin       = 1'b1;
               end else if (left_ff >= 4'd3 && left_ff <= 4'd11) begin
                  add_mask  = 4'b1111;
                  left_calc = left_ff - 4'd2;
               end
            end
         endcase
         if (word.in_last) begin
            fin = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lane_sum[i] = add_mask[i] ? fold_add(lane_ff[i], lane_of(word.in_data, 2'(i)))
                                   : lane_ff[i];
      end
      fold_a = fold_add(lane_sum[0], lane_sum[2]);
      fold_b = fold_add(lane_sum[1], lane_sum[3]);
      fold_s = fold_add(fold_a, fold_b);
      result.fin  = fin;
      result.csum = fin ? (fold_s ^ LANE_ONES) : 16'd0;
   end

   always_comb begin
      pos_in  = pos_ff;
      left_in = left_ff;
      done_in = done_ff;
      for (int i = 0; i < 4; i++) begin
         lane_in[i] = lane_ff[i];
      end
      if (step) begin
         if (word.in_last) begin
            // end of packet: next word opens a new header
            pos_in  = POS_FIRST;
            left_in = 4'd0;
            done_in = 1'b0;
            for (int i = 0; i < 4; i++) begin
               lane_in[i] = 16'd0;
            end
         end else begin
            pos_in  = pos_calc;
            left_in = left_calc;
            done_in = done_ff | fin;
            for (int i = 0; i < 4; i++) begin
               lane_in[i] = fin ? 16'd0 : lane_sum[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         left_ff <= 4'd0;
         done_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            lane_ff[i] <= 16'd0;
         end
      end else begin
         pos_ff  <= pos_in;
         left_ff <= left_in;
         done_ff <= done_in;
         for (int i = 0; i < 4; i++) begin
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   a_done_lanes_clear: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (lane_ff[0] == 16'd0 && lane_ff[1] == 16'd0 &&
                   lane_ff[2] == 16'd0 && lane_ff[3] == 16'd0))
      else $error("lane sums not cleared after checksum");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step && word.in_last |=> pos_ff == POS_FIRST && !done_ff && left_ff == 4'd0)
      else $error("state not cleared after last word");

   a_single_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !result.fin)
      else $error("second checksum in one packet");

endmodule

>>> dv/ipv4_header_checksum_64b_unit_tb.sv
// Testbench for ipv4_header_checksum_64b_unit: drives packet words, predicts every response word
// and compares it field by field, including the header checksum. Depends on ihc_pkg.
module ipv4_header_checksum_64b_unit_tb;
   import ihc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // lane masks for the sum of one word
   localparam logic [3:0] LANES_ALL      = 4'b1111;
   localparam logic [3:0] LANES_NO_CSUM  = 4'b1101;
   localparam logic [3:0] LANES_LOW_PAIR = 4'b0011;

   // payload fill for a packet
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted header state
   word_pos_type hdr_pos = POS_FIRST;
   logic [3:0]   words_left = 4'd0;
   logic [15:0]  lane_acc [4] = '{default: 16'd0};
   logic         hdr_done = 1'b0;

   rsp_type outbound_words [$];
   bit      steady = 1'b0;
   int      errors = 0;
   int      words_sent = 0;
   int      words_seen = 0;
   int      csums_seen = 0;
   int      cycle_count = 0;

   ipv4_header_checksum_64b_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  outbound_words.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // byte 2i is the high byte of lane i
   function automatic logic [15:0] be_lane(input logic [63:0] d, input int i);
      return {d[16*i +: 8], d[16*i + 8 +: 8]};
   endfunction

   function automatic void sum_lanes(input logic [63:0] d, input logic [3:0] mask);
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) lane_acc[i] = ones_add(lane_acc[i], be_lane(d, i));
      end
   endfunction

   // advance the header state by one word and return the word that should come out
   function automatic rsp_type checksum_step(input req_type w);
      rsp_type     r;
      logic        fin;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] s;
      r.out_data   = w.in_data;
      r.out_keep   = w.in_keep;
      r.out_last   = w.in_last;
      r.csum_valid = 1'b0;
      r.csum       = 16'd0;
      fin = 1'b0;
      if (!hdr_done) begin
         case (hdr_pos)
            POS_FIRST: begin
               sum_lanes(w.in_data, LANES_ALL);
               words_left = w.in_data[3:0] - 4'd2;
               hdr_pos = POS_SECOND;
            end
            POS_SECOND: begin
               sum_lanes(w.in_data, LANES_NO_CSUM);
               words_left = words_left - 4'd2;
               hdr_pos = POS_BODY;
            end
            default: begin
               if (words_left == 4'd1) begin
                  sum_lanes(w.in_data, LANES_LOW_PAIR);
                  words_left = 4'd0;
                  fin = 1'b1;
               end else if (words_left == 4'd2) begin
                  sum_lanes(w.in_data, LANES_ALL);
                  words_left = 4'd0;
                  fin = 1'b1;
               end else if (words_left >= 4'd3 && words_left <= 4'd11) begin
                  sum_lanes(w.in_data, LANES_ALL);
                  words_left = words_left - 4'd2;
               end
            end
         endcase
         if (w.in_last) fin = 1'b1;
         if (fin) begin
            a = ones_add(lane_acc[0], lane_acc[2]);
            b = ones_add(lane_acc[1], lane_acc[3]);
            s = ones_add(a, b);
            r.csum_valid = 1'b1;
            r.csum = ~s;
            lane_acc = '{default: 16'd0};
            hdr_done = 1'b1;
         end
      end
      if (w.in_last) begin
         hdr_pos = POS_FIRST;
         words_left = 4'd0;
         lane_acc = '{default: 16'd0};
         hdr_done = 1'b0;
      end
      return r;
   endfunction

   task automatic send_word(input req_type w);
      if (!steady) begin
         while ($urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      outbound_words.push_back(checksum_step(w));
      words_sent++;
   endtask

   task automatic send_packet(input logic [3:0] ihl, input int n_words, input int fill);
      req_type w;
      for (int i = 0; i < n_words; i++) begin
         case (fill)
            FILL_ZERO: begin
               w.in_data = 64'd0;
               w.in_keep = 8'h00;
            end
            FILL_ONES: begin
               w.in_data = {64{1'b1}};
               w.in_keep = 8'hFF;
            end
            default: begin
               w.in_data = {$urandom, $urandom};
               w.in_keep = 8'($urandom);
            end
         endcase
         if (i == 0) w.in_data[3:0] = ihl;
         w.in_last = (i == n_words - 1);
         send_word(w);
      end
   endtask

   // hold the sender until every predicted word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (outbound_words.size() != 0) @(posedge clock);
   endtask

   // header lengths at the edges, short headers, truncation, trailing words
   task automatic test_directed_headers();
      send_packet(4'd5, 4, FILL_ONES);
      send_packet(4'd6, 3, FILL_ZERO);
      send_packet(4'd15, 7, FILL_RANDOM);
      send_packet(4'd4, 3, FILL_RANDOM);
      send_packet(4'd0, 2, FILL_ONES);
      send_packet(4'd5, 1, FILL_RANDOM);
      send_packet(4'd15, 3, FILL_ONES);
   endtask

   task automatic test_random_traffic(input int n_words);
      int          stop_at;
      int          pick;
      int          span;
      logic [3:0]  ihl;
      req_type     w;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            ihl = 4'($urandom_range(5, 15));
            span = (int'(ihl) * 4 + 7) / 8;
            send_packet(ihl, span + $urandom_range(0, 4), FILL_RANDOM);
         end else if (pick < 82) begin
            send_packet(4'($urandom_range(0, 4)), $urandom_range(1, 6), FILL_RANDOM);
         end else if (pick < 94) begin
            ihl = 4'($urandom_range(5, 15));
            span = (int'(ihl) * 4 + 7) / 8;
            send_packet(ihl, $urandom_range(1, span - 1), FILL_RANDOM);
         end else begin
            // stray word with a random last flag
            w.in_data = {$urandom, $urandom};
            w.in_keep = 8'($urandom);
            w.in_last = 1'($urandom);
            send_word(w);
         end
      end
   endtask

   task automatic test_steady_stream(input int n_words);
      steady = 1'b1;
      test_random_traffic(n_words);
      steady = 1'b0;
   endtask

   // check each response word against the oldest prediction
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            words_seen++;
            if (outbound_words.size() == 0) begin
               $error("unexpected response word: data %h", rsp_data.out_data);
               errors++;
            end else begin
               want = outbound_words.pop_front();
               if (want.csum_valid) csums_seen++;
               if (rsp_data.out_data !== want.out_data) begin
                  $error("out_data: expected %h, got %h", want.out_data, rsp_data.out_data);
                  errors++;
               end
               if (rsp_data.out_keep !== want.out_keep) begin
                  $error("out_keep: expected %h, got %h", want.out_keep, rsp_data.out_keep);
                  errors++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
                  errors++;
               end
               if (rsp_data.csum_valid !== want.csum_valid) begin
                  $error("csum_valid: expected %b, got %b", want.csum_valid,
                         rsp_data.csum_valid);
                  errors++;
               end
               if (rsp_data.csum !== want.csum) begin
                  $error("csum: expected %h, got %h", want.csum, rsp_data.csum);
                  errors++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 31);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_headers();
      wait_for_results();
      test_random_traffic(380);
      wait_for_results();
      test_steady_stream(150);
      wait_for_results();
      test_random_traffic(100);
      wait_for_results();
      // let any stray word surface
      repeat (8) @(posedge clock);
      if (outbound_words.size() != 0) begin
         $error("%0d predicted words never came back", outbound_words.size());
         errors++;
      end
      $display("sent %0d words, got %0d back with %0d checksums, %0d mismatches",
               words_sent, words_seen, csums_seen, errors);
      $display("covered header lengths 0 to 15, truncated packets and stray words");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
